FILE: sv/sgbs_pkg.sv
// Shared types and constants for the split gain best bin scan core.
// Used by sgbs_term_unit and split_gain_best_bin_scan_core.
package sgbs_pkg;

    localparam int MAX_BINS_DEF = 256;
    localparam int MAG_W        = 41;   // magnitude of a gradient sum
    localparam int DEN_W        = 41;   // hessian sum plus lambda
    localparam int SQ_W         = 81;   // square of a magnitude
    localparam int TERM_W       = 61;   // term, capped at 2**60
    localparam int GAIN_W       = 48;

    localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

    typedef enum logic [1:0] {
        T_FIN = 2'd0,
        T_INF = 2'd1,
        T_NAN = 2'd2
    } t_term_st;

    // register indexes on the configuration port
    localparam logic [1:0] REG_TOT_GRAD = 2'd0;
    localparam logic [1:0] REG_TOT_HESS = 2'd1;
    localparam logic [1:0] REG_MIN_CW   = 2'd2;
    localparam logic [1:0] REG_RIDGE    = 2'd3;

endpackage

FILE: sv/sgbs_term_unit.sv
// Shared term unit: q = m*m / d, squared over three 32x32 products and
// divided bit-serially, one quotient bit per cycle. Depends on sgbs_pkg.
module sgbs_term_unit
    import sgbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MAG_W-1:0]  i_mag,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [TERM_W-1:0] o_term,
    output t_term_st          o_status
);

    typedef enum logic [2:0] {
        U_IDLE = 3'b001,
        U_MUL  = 3'b010,
        U_DIV  = 3'b100
    } t_ustate;

    t_ustate          r_st;
    logic [6:0]       r_cnt;
    logic [MAG_W-1:0] r_mag;
    logic [DEN_W-1:0] r_den;
    logic [SQ_W-1:0]  r_acc;
    logic [DEN_W-1:0] r_rem;
    logic             r_done;
    t_term_st         r_status;

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    logic [DEN_W:0] w_rem_sh;
    logic        w_ge;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                w_ma = r_mag[31:0];
                w_mb = r_mag[31:0];
            end
            2'd1: begin
                w_ma = 32'(r_mag[MAG_W-1:32]);
                w_mb = r_mag[31:0];
            end
            default: begin
                w_ma = 32'(r_mag[MAG_W-1:32]);
                w_mb = 32'(r_mag[MAG_W-1:32]);
            end
        endcase
    end

    assign w_prod   = w_ma * w_mb;
    assign w_rem_sh = {r_rem, r_acc[SQ_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= U_IDLE;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                U_IDLE: begin
                    if (i_start) begin
                        r_mag <= i_mag;
                        r_den <= i_den;
                        r_cnt <= '0;
                        if (i_den == '0) begin
                            r_status <= (i_mag == '0) ? T_NAN : T_INF;
                            r_acc    <= '0;
                            r_done   <= 1'b1;
                        end else begin
                            r_status <= T_FIN;
                            r_st     <= U_MUL;
                        end
                    end
                end
                U_MUL: begin
                    case (r_cnt[1:0])
                        2'd0:    r_acc <= SQ_W'(w_prod);
                        2'd1:    r_acc <= r_acc + (SQ_W'(w_prod) << 33);
                        default: r_acc <= r_acc + (SQ_W'(w_prod) << 64);
                    endcase
                    if (r_cnt == 7'd2) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_st  <= U_DIV;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                U_DIV: begin
                    // restoring step: quotient bits shift in where dividend bits leave
                    r_rem <= w_ge ? DEN_W'(w_rem_sh - {1'b0, r_den}) : DEN_W'(w_rem_sh);
                    r_acc <= {r_acc[SQ_W-2:0], w_ge};
                    if (r_cnt == 7'(SQ_W - 1)) begin
                        r_done <= 1'b1;
                        r_st   <= U_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                default: r_st <= U_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_term   = (|r_acc[SQ_W-1:TERM_W-1]) ? {1'b1, {(TERM_W-1){1'b0}}}
                                                : r_acc[TERM_W-1:0];

endmodule

FILE: sv/split_gain_best_bin_scan_core.sv
// Best split scan over one feature histogram, top level.
// Depends on sgbs_pkg and sgbs_term_unit.
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid/tready             tdata: bin_grad, bin_hess; tlast: last_bin
//  m_axis    out  tvalid/tready             tdata: best_bin .. bin_overflow
//  apb       in   psel/penable/pwrite       paddr 8*i, pwdata/prdata 64 bit
//
// A bin in range that meets the weight check passes, from its transfer to the
// next possible transfer, through the check state, three gain terms (start,
// three partial products, 81 divide steps, done) in the one shared term
// unit, and the gain and finish states. A term with a zero denominator skips
// the products and divide steps. A bin that fails the weight check passes only
// check and finish, a bin past the bin limit only finish; a last bin adds the output state.
// The slave side is ready only while the sequencer is idle; a finished
// result waits in the output register while the next scan goes on, and a
// second result stalls in the output state until the first is taken.
// Reset is synchronous, active low, and clears config and most scan state.
module split_gain_best_bin_scan_core
    import sgbs_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // [31:0] bin_grad, [63:32] bin_hess
    input  logic         s_axis_tlast,   // last_bin
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] best_bin, [55:8] best_gain, [95:56] best_left_grad,
    // [134:96] best_left_hess, [135] split_found, [136] bin_overflow
    output logic [143:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int CW = $clog2(MAX_BINS + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHK    = 7'b0000010,
        S_TSTART = 7'b0000100,
        S_TWAIT  = 7'b0001000,
        S_GAIN   = 7'b0010000,
        S_FIN    = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    // configuration
    logic signed [39:0] r_tot_grad;
    logic [38:0]        r_tot_hess;
    logic [31:0]        r_min_cw;
    logic [31:0]        r_lambda;

    // scan state
    t_state             r_state;
    logic signed [39:0] r_lg;
    logic [39:0]        r_lh;
    logic signed [GAIN_W-1:0] r_best_gain;
    logic [7:0]         r_best_bin;
    logic signed [39:0] r_best_lg;
    logic [39:0]        r_best_lh;
    logic               r_found;
    logic [CW-1:0]      r_bin_cnt;
    logic               r_ovf;
    logic               r_last;
    logic               r_in_range;
    logic [1:0]         r_tidx;
    logic [TERM_W-1:0]  r_tq [3];
    t_term_st           r_tst [3];

    // output register
    logic               r_out_valid;
    logic [143:0]       r_out_data;

    logic w_cfg_wr, w_accept, w_load;
    logic signed [31:0] w_g;
    logic signed [40:0] w_ng, w_rg, w_rh, w_sg;
    logic [40:0]        w_nh;
    logic [39:0]        w_sh;
    logic [MAG_W-1:0]   w_mag;
    logic [DEN_W-1:0]   w_den;
    logic               w_tdone;
    logic [TERM_W-1:0]  w_term;
    t_term_st           w_tst;
    logic signed [62:0] w_sum;
    logic signed [GAIN_W-1:0] w_gain;
    logic               w_skip, w_wt_ok;
    logic [38:0]        w_out_lh;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[4:3])
            REG_TOT_GRAD: prdata = 64'(unsigned'(r_tot_grad));
            REG_TOT_HESS: prdata = 64'(r_tot_hess);
            REG_MIN_CW:   prdata = 64'(r_min_cw);
            REG_RIDGE:    prdata = 64'(r_lambda);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_grad <= '0;
            r_tot_hess <= '0;
            r_min_cw   <= 32'd65536;
            r_lambda   <= 32'd65536;
        end else if (w_cfg_wr) begin
            case (paddr[4:3])
                REG_TOT_GRAD: r_tot_grad <= pwdata[39:0];
                REG_TOT_HESS: r_tot_hess <= pwdata[38:0];
                REG_MIN_CW:   r_min_cw   <= pwdata[31:0];
                REG_RIDGE:    r_lambda   <= pwdata[31:0];
                default:      ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // saturating running left sums
    assign w_g  = s_axis_tdata[31:0];
    assign w_ng = 41'(r_lg) + 41'(w_g);
    assign w_nh = {1'b0, r_lh} + 41'(s_axis_tdata[63:32]);

    // right sums from the node totals
    assign w_rg = 41'(r_tot_grad) - 41'(r_lg);
    assign w_rh = $signed({2'b00, r_tot_hess}) - $signed({1'b0, r_lh});
    assign w_wt_ok = (r_lh >= {8'd0, r_min_cw}) && (w_rh >= $signed({9'd0, r_min_cw}));

    // term operands: left, right, parent
    always_comb begin
        case (r_tidx)
            2'd0: begin
                w_sg = 41'(r_lg);
                w_sh = r_lh;
            end
            2'd1: begin
                w_sg = w_rg;
                w_sh = w_rh[39:0];
            end
            default: begin
                w_sg = 41'(r_tot_grad);
                w_sh = 40'(r_tot_hess);
            end
        endcase
    end
    assign w_mag = w_sg[40] ? MAG_W'(-w_sg) : MAG_W'(w_sg);
    assign w_den = DEN_W'(w_sh) + DEN_W'(r_lambda);

    sgbs_term_unit u_term (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_TSTART),
        .i_mag    (w_mag),
        .i_den    (w_den),
        .o_done   (w_tdone),
        .o_term   (w_term),
        .o_status (w_tst)
    );

    // gain = left + right - parent, then saturate to Q32.16
    assign w_sum = 63'(r_tq[0]) + 63'(r_tq[1]) - 63'(r_tq[2]);
    always_comb begin
        if (r_tst[0] == T_INF || r_tst[1] == T_INF)
            w_gain = GAIN_MAX;
        else if (w_sum > 63'(GAIN_MAX))
            w_gain = GAIN_MAX;
        else if (w_sum < 63'(GAIN_MIN))
            w_gain = GAIN_MIN;
        else
            w_gain = GAIN_W'(w_sum);
    end
    assign w_skip = (r_tst[0] == T_NAN) || (r_tst[1] == T_NAN) || (r_tst[2] != T_FIN);

    assign w_out_lh = r_best_lh[39] ? {39{1'b1}} : r_best_lh[38:0];
    assign w_load   = (r_state == S_OUT) && (!r_out_valid || m_axis_tready);

    // hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lg        <= '0;
            r_lh        <= '0;
            r_best_gain <= GAIN_MIN;
            r_best_bin  <= '0;
            r_best_lg   <= '0;
            r_best_lh   <= '0;
            r_found     <= 1'b0;
            r_bin_cnt   <= '0;
            r_ovf       <= 1'b0;
            r_tidx      <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last <= s_axis_tlast;
                        if (r_bin_cnt < CW'(MAX_BINS)) begin
                            r_in_range <= 1'b1;
                            r_lg <= (w_ng > 41'sh0_7F_FFFF_FFFF) ? 40'sh7F_FFFF_FFFF :
                                    (w_ng < -41'sh0_80_0000_0000) ? 40'sh80_0000_0000 :
                                    40'(w_ng);
                            r_lh <= w_nh[40] ? {40{1'b1}} : w_nh[39:0];
                            r_state <= S_CHK;
                        end else begin
                            // drop the bin, flag the overrun
                            r_in_range <= 1'b0;
                            r_ovf      <= 1'b1;
                            r_state    <= S_FIN;
                        end
                    end
                end
                S_CHK: begin
                    r_tidx <= '0;
                    if (w_wt_ok) begin
                        r_found <= 1'b1;
                        r_state <= S_TSTART;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_TSTART: r_state <= S_TWAIT;
                S_TWAIT: begin
                    if (w_tdone) begin
                        r_tq[r_tidx]  <= w_term;
                        r_tst[r_tidx] <= w_tst;
                        if (r_tidx == 2'd2) begin
                            r_state <= S_GAIN;
                        end else begin
                            r_tidx  <= r_tidx + 2'd1;
                            r_state <= S_TSTART;
                        end
                    end
                end
                S_GAIN: begin
                    // keep the first strictly best bin
                    if (!w_skip && w_gain > r_best_gain) begin
                        r_best_gain <= w_gain;
                        r_best_bin  <= 8'(r_bin_cnt);
                        r_best_lg   <= r_lg;
                        r_best_lh   <= r_lh;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_in_range)
                        r_bin_cnt <= r_bin_cnt + CW'(1);
                    r_state <= r_last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_out_data  <= {7'd0, r_ovf, r_found, w_out_lh, r_best_lg,
                                        r_best_gain, r_best_bin};
                        // start the next scan
                        r_lg        <= '0;
                        r_lh        <= '0;
                        r_best_gain <= GAIN_MIN;
                        r_best_bin  <= '0;
                        r_best_lg   <= '0;
                        r_best_lh   <= '0;
                        r_found     <= 1'b0;
                        r_bin_cnt   <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tdone |-> r_state == S_TWAIT)
        else $error("term unit finished outside the wait state");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bin_cnt <= CW'(MAX_BINS))
        else $error("bin counter ran past the bin limit");

    a_scan_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_lg == '0 && r_lh == '0 && !r_found && r_bin_cnt == '0))
        else $error("scan state not cleared after a result");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> m_axis_tvalid)
        else $error("result not presented after load");
`endif

endmodule

FILE: tb/testbench.sv
// Testbench for split_gain_best_bin_scan_core: streams histogram bins, mirrors
// the split gain scan in a local predictor and checks every reported split.
// Depends on sgbs_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
    import sgbs_pkg::*;

    typedef struct {
        logic [31:0] grad;
        logic [31:0] hess;
        logic        last;
    } t_bin_item;

    typedef struct {
        logic [7:0]  bin;
        logic [47:0] gain;
        logic [39:0] left_grad;
        logic [38:0] left_hess;
        logic        found;
        logic        ovf;
    } t_split;

    localparam int SCAN_LATENCY = 400;
    localparam int WATCHDOG_LIM = 20000;
    localparam int LONG_HOLD    = 1500;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;   // [31:0] bin_grad, [63:32] bin_hess
    logic         s_axis_tlast;   // last_bin
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [7:0] best_bin, [55:8] best_gain, [95:56] best_left_grad,
    // [134:96] best_left_hess, [135] split_found, [136] bin_overflow
    logic [143:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    split_gain_best_bin_scan_core DUT (.*);

    // stimulus and expectation stores
    t_bin_item   bins_pending[$];
    t_split      splits_due[$];

    // configuration mirror
    longint          cfg_tot_grad;
    longint unsigned cfg_tot_hess;
    longint unsigned cfg_min_cw;
    longint unsigned cfg_lambda;

    // scan state mirror
    longint          acc_grad;
    longint unsigned acc_hess;
    longint          top_gain;
    int              top_bin;
    longint          top_grad;
    longint unsigned top_hess;
    bit              any_found;
    int              bin_count;
    bit              any_ovf;

    int  mismatches;
    int  bins_sent;
    int  scans_checked;
    int  splits_seen;
    int  ovf_seen;
    int  idle_cycles;
    bit  in_taken;
    bit  tail_no_idle;
    int  src_gap;
    int  snk_gap;
    int  hold_left;
    int  hold_reqs;
    int  hold_served;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("MISMATCH scan %0d %s: got %h expected %h", scans_checked, what, got, want);
    endtask

    task automatic clear_scan();
        acc_grad  = 0;
        acc_hess  = 0;
        top_gain  = -(longint'(1) << 47);
        top_bin   = 0;
        top_grad  = 0;
        top_hess  = 0;
        any_found = 0;
        bin_count = 0;
        any_ovf   = 0;
    endtask

    // g^2/(h+lambda) on raw Q16.16 values, rounded toward zero, capped at 2^60
    function automatic t_term_st split_term(input longint g, input longint unsigned h,
                                            output longint unsigned val);
        logic [127:0] mag, den, sq, quo;
        mag = (g < 0) ? 128'(-g) : 128'(g);
        den = 128'(h) + 128'(cfg_lambda);
        val = 0;
        if (den == 0)
            return (mag == 0) ? T_NAN : T_INF;
        sq  = mag * mag;
        quo = sq / den;
        val = (quo >= (128'(1) << 60)) ? (64'(1) << 60) : quo[63:0];
        return T_FIN;
    endfunction

    task automatic evaluate_bin();
        longint          rg, rh, gain;
        longint unsigned tl, tr, tp;
        t_term_st        sl, sr, sp;
        rg = cfg_tot_grad - acc_grad;
        rh = longint'(cfg_tot_hess) - longint'(acc_hess);
        if (acc_hess < cfg_min_cw || rh < longint'(cfg_min_cw))
            return;
        any_found = 1;
        sl = split_term(acc_grad, acc_hess, tl);
        sr = split_term(rg, longint'(rh), tr);
        sp = split_term(cfg_tot_grad, cfg_tot_hess, tp);
        if (sl == T_NAN || sr == T_NAN || sp != T_FIN)
            return;
        if (sl == T_INF || sr == T_INF) begin
            gain = longint'(GAIN_MAX);
        end else begin
            gain = longint'(tl) + longint'(tr) - longint'(tp);
            if (gain > longint'(GAIN_MAX)) gain = longint'(GAIN_MAX);
            if (gain < longint'(GAIN_MIN)) gain = longint'(GAIN_MIN);
        end
        if (gain > top_gain) begin
            top_gain = gain;
            top_bin  = bin_count;
            top_grad = acc_grad;
            top_hess = acc_hess;
        end
    endtask

    // advance the scan by one bin; queue the split when the bin closes the scan
    task automatic scan_bin(input t_bin_item b);
        t_split r;
        longint ng;
        longint unsigned nh;
        if (bin_count < MAX_BINS_DEF) begin
            ng = acc_grad + longint'(signed'(b.grad));
            nh = acc_hess + longint'(b.hess);
            if (ng > 64'sh7F_FFFF_FFFF) ng = 64'sh7F_FFFF_FFFF;
            if (ng < -64'sh80_0000_0000) ng = -64'sh80_0000_0000;
            if (nh > 64'hFF_FFFF_FFFF) nh = 64'hFF_FFFF_FFFF;
            acc_grad = ng;
            acc_hess = nh;
            evaluate_bin();
            bin_count++;
        end else begin
            any_ovf = 1;
        end
        if (!b.last)
            return;
        r.bin       = top_bin[7:0];
        r.gain      = top_gain[47:0];
        r.left_grad = top_grad[39:0];
        r.left_hess = (top_hess > 64'h7F_FFFF_FFFF) ? 39'h7F_FFFF_FFFF : top_hess[38:0];
        r.found     = any_found;
        r.ovf       = any_ovf;
        splits_due.push_back(r);
        clear_scan();
    endtask

    // APB write: setup cycle, then access cycle; mirror the register after it lands
    task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TOT_GRAD: cfg_tot_grad = longint'(signed'(val[39:0]));
            REG_TOT_HESS: cfg_tot_hess = val[38:0];
            REG_MIN_CW:   cfg_min_cw   = val[31:0];
            REG_RIDGE:    cfg_lambda   = val[31:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [63:0] tg, input logic [63:0] th,
                             input logic [63:0] mcw, input logic [63:0] lam);
        reg_write(REG_TOT_GRAD, tg);
        reg_write(REG_TOT_HESS, th);
        reg_write(REG_MIN_CW, mcw);
        reg_write(REG_RIDGE, lam);
    endtask

    // wait for all results to drain, then let any in-flight bin finish
    task automatic drain();
        wait (bins_pending.size() == 0 && !s_axis_tvalid && splits_due.size() == 0);
        repeat (SCAN_LATENCY) @(posedge i_clk);
    endtask

    task automatic push_bin(input logic [31:0] g, input logic [31:0] h, input logic l);
        t_bin_item b;
        b.grad = g;
        b.hess = h;
        b.last = l;
        bins_pending.push_back(b);
        bins_sent++;
    endtask

    // one scan of n bins with random content scaled to the phase
    task automatic push_scan(input int n, input logic [31:0] gscale, input logic [31:0] hscale);
        logic [31:0] g, h;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                g = $urandom;
                h = $urandom;
            end else begin
                g = $urandom_range(0, gscale);
                if ($urandom_range(0, 1)) g = -g;
                h = $urandom_range(0, hscale);
            end
            push_bin(g, h, i == n - 1);
        end
    endtask

    // stimulus: directed phases, then random phases and a closing stretch
    initial begin
        logic [31:0] gscale, hscale;
        logic [63:0] tg, th, mcw, lam;
        int          n;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_tot_grad = 0;
        cfg_tot_hess = 0;
        cfg_min_cw = 65536;
        cfg_lambda = 65536;
        clear_scan();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset totals: right hessian always negative, nothing qualifies
        push_bin(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        push_bin(32'h8000_0000, 32'h0000_0000, 1'b1);
        drain();

        // zero lambda, zero weight, zero totals: undefined parent skips every bin
        configure(64'h0, 64'h0, 64'h0, 64'h0);
        push_bin(32'h0, 32'h0, 1'b0);
        push_bin(32'h0, 32'h0, 1'b1);
        drain();

        // infinite left term with a finite parent saturates the gain high
        configure(64'h0_0003_0000, 64'h40_0000, 64'h0, 64'h0);
        push_bin(32'h0000_0005, 32'h0, 1'b0);
        push_bin(32'h0001_0000, 32'h1_0000, 1'b0);
        push_bin(32'hFFFF_0000, 32'h0, 1'b1);
        drain();

        // extreme totals and extreme weight: large terms, all below the 2^60 cap
        configure(64'h7F_FFFF_FFFF, 64'h7F_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF);
        push_bin(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        push_bin(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        push_bin(32'h7FFF_FFFF, 32'h0, 1'b1);
        drain();

        // most negative total, maximal weight: both bins still qualify
        configure(64'h80_0000_0000, 64'h7F_FFFF_FFFF, 64'hFFFF_FFFF, 64'h0);
        push_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        push_bin(32'h1234_5678, 32'h8000_0000, 1'b1);
        drain();

        // huge parent, zero-gradient bins: capped terms cancel, then an infinite right term
        configure(64'h7F_FFFF_FFFF, 64'h2_0000, 64'h0, 64'h0);
        push_bin(32'h0, 32'h1_0000, 1'b0);
        push_bin(32'h0, 32'h1_0000, 1'b1);
        drain();

        // random phases; one of them runs a held receiver
        for (int phase = 0; bins_sent < 1000; phase++) begin
            gscale = 32'hFFFF_FFFF >> $urandom_range(1, 16);
            hscale = 32'hFFFF_FFFF >> $urandom_range(0, 16);
            th = 64'(hscale) * $urandom_range(1, 6);
            tg = $urandom_range(0, 1) ? 64'(gscale) * $urandom_range(0, 4) :
                 -(64'(gscale) * $urandom_range(0, 4));
            case ($urandom_range(0, 3))
                0: mcw = 0;
                1: mcw = $urandom_range(0, hscale);
                2: mcw = $urandom;
                default: mcw = 65536;
            endcase
            case ($urandom_range(0, 3))
                0: lam = 0;
                1: lam = 32'hFFFF_FFFF;
                default: lam = $urandom;
            endcase
            if ($urandom_range(0, 7) == 0) th = {$urandom, $urandom};
            configure(tg, th, mcw, lam);
            if (phase == 2) hold_reqs++;
            if (phase == 4) begin
                push_scan(258, gscale, hscale);
                push_scan(1, gscale, hscale);
            end
            for (int s = 0; s < 8; s++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
                push_scan(n, gscale, hscale);
            end
            drain();
        end

        // closing stretch with no idling on either side
        tail_no_idle = 1;
        for (int s = 0; s < 8; s++) begin
            n = $urandom_range(1, 10);
            push_scan(n, gscale, hscale);
        end
        drain();

        $display("Covered %0d bins in %0d scans: %0d with a split, %0d with bin overflow.",
                 bins_sent, scans_checked, splits_seen, ovf_seen);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // bin driver: hold data until the transfer, idle in random bursts
    always @(negedge i_clk) begin
        bit        v;
        t_bin_item b;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            v = 0;
            if (src_gap > 0) begin
                src_gap--;
            end else if (!tail_no_idle && $urandom_range(0, 11) == 0) begin
                src_gap = $urandom_range(0, 15);
            end else if (bins_pending.size() != 0) begin
                b = bins_pending.pop_front();
                v = 1;
                s_axis_tdata <= {b.hess, b.grad};
                s_axis_tlast <= b.last;
            end
            s_axis_tvalid <= v;
        end
    end

    // result receiver: random stalls plus one long hold to back up the core
    always @(negedge i_clk) begin
        bit r;
        r = 1;
        if (!i_rst_n) begin
            r = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            r = 0;
        end else if (hold_reqs != hold_served) begin
            hold_served++;
            hold_left = LONG_HOLD;
            r = 0;
        end else if (snk_gap > 0) begin
            snk_gap--;
            r = 0;
        end else if (!tail_no_idle && $urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(0, 15);
            r = 0;
        end
        m_axis_tready <= r;
    end

    // predict on input transfers, check output transfers, watch for hangs
    always @(posedge i_clk) begin
        t_bin_item b;
        t_split    w;
        bit        active;
        active = 0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            b.grad = s_axis_tdata[31:0];
            b.hess = s_axis_tdata[63:32];
            b.last = s_axis_tlast;
            scan_bin(b);
            active = 1;
        end
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            active = 1;
            if (splits_due.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
            end else begin
                w = splits_due.pop_front();
                if (m_axis_tdata[7:0] !== w.bin)
                    report_mismatch("best_bin", m_axis_tdata[7:0], w.bin);
                if (m_axis_tdata[55:8] !== w.gain)
                    report_mismatch("best_gain", m_axis_tdata[55:8], w.gain);
                if (m_axis_tdata[95:56] !== w.left_grad)
                    report_mismatch("best_left_grad", m_axis_tdata[95:56], w.left_grad);
                if (m_axis_tdata[134:96] !== w.left_hess)
                    report_mismatch("best_left_hess", m_axis_tdata[134:96], w.left_hess);
                if (m_axis_tdata[135] !== w.found)
                    report_mismatch("split_found", m_axis_tdata[135], w.found);
                if (m_axis_tdata[136] !== w.ovf)
                    report_mismatch("bin_overflow", m_axis_tdata[136], w.ovf);
                splits_seen += w.found;
                ovf_seen += w.ovf;
            end
            scans_checked++;
        end
        idle_cycles = active ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIM) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIM);
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

FILE: files.f
sv/sgbs_pkg.sv
sv/sgbs_term_unit.sv
sv/split_gain_best_bin_scan_core.sv
tb/testbench.sv
